[hw/rtl/nsr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nsr_pkg
// Shared types and constants for the Newton square root block.
// ----------------------------------------------------------------------------
package nsr_pkg;

   localparam int TOL_WIDTH   = 16;
   localparam int CAP_WIDTH   = 7;
   localparam int CSR_WIDTH   = 16;
   localparam int INDEX_WIDTH = 1;

   typedef logic [INDEX_WIDTH-1:0] csr_index_type;

   localparam csr_index_type CSR_TOLERANCE     = 1'b0;
   localparam csr_index_type CSR_ITERATION_CAP = 1'b1;

   localparam logic [TOL_WIDTH-1:0] TOLERANCE_RESET     = 16'd7;
   localparam logic [CAP_WIDTH-1:0] ITERATION_CAP_RESET = 7'd32;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_UPDATE,
      ST_CHECK,
      ST_FINISH
   } nsr_state_type;

endpackage
`default_nettype wire

[hw/rtl/nsr_divider.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nsr_divider
// Restoring radix-2 divider: (num << FRACTION_BITS) / den, one quotient bit
// per cycle, saturating to all ones when the quotient overflows.
// ----------------------------------------------------------------------------
module nsr_divider #(
   parameter int VALUE_WIDTH   = 32,
   parameter int FRACTION_BITS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [VALUE_WIDTH-1:0] numerator,
   input  wire logic [VALUE_WIDTH-1:0] denominator,
   output logic                        done,
   output logic [VALUE_WIDTH-1:0]      quotient
);

   localparam int STEPS       = VALUE_WIDTH + FRACTION_BITS;
   localparam int COUNT_WIDTH = $clog2(STEPS + 1);

   logic [VALUE_WIDTH:0]       rem_ff, rem_in;
   logic [VALUE_WIDTH-1:0]     quot_ff, quot_in;
   logic [VALUE_WIDTH-1:0]     num_ff, num_in;
   logic [VALUE_WIDTH-1:0]     den_ff, den_in;
   logic                       over_ff, over_in;
   logic [COUNT_WIDTH-1:0]     count_ff, count_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;

   logic [VALUE_WIDTH:0]       rem_shift;
   logic                       fits;

   // Numerator bits shift out at the top; zeros fill in for the fraction bits.
   assign rem_shift = {rem_ff[VALUE_WIDTH-1:0], num_ff[VALUE_WIDTH-1]};
   assign fits      = rem_shift >= {1'b0, den_ff};

   always_comb begin
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      over_in  = over_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         rem_in   = '0;
         quot_in  = '0;
         num_in   = numerator;
         den_in   = denominator;
         over_in  = 1'b0;
         count_in = COUNT_WIDTH'(STEPS);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_in   = fits ? rem_shift - {1'b0, den_ff} : rem_shift;
         quot_in  = {quot_ff[VALUE_WIDTH-2:0], fits};
         // a one leaving the top means the quotient does not fit
         over_in  = over_ff | quot_ff[VALUE_WIDTH-1];
         num_in   = {num_ff[VALUE_WIDTH-2:0], 1'b0};
         count_in = count_ff - 1'b1;
         if (count_ff == COUNT_WIDTH'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      quot_ff  <= quot_in;
      num_ff   <= num_in;
      den_ff   <= den_in;
      over_ff  <= over_in;
      count_ff <= count_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = over_ff ? '1 : quot_ff;

endmodule
`default_nettype wire

[hw/rtl/newton_square_root.sv]
`timescale 1ns / 1ps
`default_nettype none
// Rounds: each Newton round runs one serial divide of the radicand by the guess at
//   Q16.16 by default, then the ST_UPDATE and ST_CHECK states.
// Throughput: one request at a time; the next is taken once the result is
//   registered, while that result may still wait on the output.
// Reset: synchronous, active high; restores tolerance 7 and iteration cap 32.
// ----------------------------------------------------------------------------
// newton_square_root
// Fixed-point square root by Heron iteration over a shared serial divider.
// ----------------------------------------------------------------------------
module newton_square_root #(
   parameter int FRACTION_BITS = 16,
   parameter int VALUE_WIDTH   = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_write_enable,
   input  wire nsr_pkg::csr_index_type        csr_index,
   input  wire logic [nsr_pkg::CSR_WIDTH-1:0] csr_write_data,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [VALUE_WIDTH-1:0]        req_radicand,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [VALUE_WIDTH-1:0]             rsp_root,
   output logic [nsr_pkg::CAP_WIDTH-1:0]      rsp_rounds_used,
   output logic                               rsp_cap_reached
);

   localparam logic [VALUE_WIDTH-1:0] ONE_FIXED = VALUE_WIDTH'(1) << FRACTION_BITS;

   nsr_pkg::nsr_state_type              state_ff, state_in;
   logic [nsr_pkg::TOL_WIDTH-1:0]       tolerance_ff, tolerance_in;
   logic [nsr_pkg::CAP_WIDTH-1:0]       cap_ff, cap_in;
   logic [VALUE_WIDTH-1:0]              rad_ff, rad_in;
   logic [VALUE_WIDTH-1:0]              guess_ff, guess_in;
   logic [VALUE_WIDTH-1:0]              quot_hold_ff, quot_hold_in;
   logic [nsr_pkg::CAP_WIDTH-1:0]       rounds_ff, rounds_in;
   logic                                err_over_ff, err_over_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [VALUE_WIDTH-1:0]              rsp_root_ff, rsp_root_in;
   logic [nsr_pkg::CAP_WIDTH-1:0]       rsp_rounds_ff, rsp_rounds_in;
   logic                                rsp_cap_ff, rsp_cap_in;

   logic                                out_free;
   logic                                div_start;
   logic [VALUE_WIDTH-1:0]              div_num;
   logic [VALUE_WIDTH-1:0]              div_den;
   logic                                div_done;
   logic [VALUE_WIDTH-1:0]              div_quot;
   logic [VALUE_WIDTH:0]                sum;
   logic [VALUE_WIDTH-1:0]              err;
   logic [nsr_pkg::CAP_WIDTH-1:0]       cap_eff;

   nsr_divider #(
      .VALUE_WIDTH   (VALUE_WIDTH),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_divider (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .numerator   (div_num),
      .denominator (div_den),
      .done        (div_done),
      .quotient    (div_quot)
   );

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign sum        = {1'b0, div_quot} + {1'b0, guess_ff};
   // guess_ff holds the new mean here, quot_hold_ff the quotient it came from
   assign err        = (guess_ff >= quot_hold_ff) ? guess_ff - quot_hold_ff
                                                  : quot_hold_ff - guess_ff;
   assign cap_eff    = (cap_ff == '0) ? nsr_pkg::CAP_WIDTH'(1) : cap_ff;

   // configuration registers
   always_comb begin
      tolerance_in = tolerance_ff;
      cap_in       = cap_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            nsr_pkg::CSR_TOLERANCE:     tolerance_in = csr_write_data;
            nsr_pkg::CSR_ITERATION_CAP: cap_in = csr_write_data[nsr_pkg::CAP_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      rad_in        = rad_ff;
      guess_in      = guess_ff;
      quot_hold_in  = quot_hold_ff;
      rounds_in     = rounds_ff;
      err_over_in   = err_over_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_root_in   = rsp_root_ff;
      rsp_rounds_in = rsp_rounds_ff;
      rsp_cap_in    = rsp_cap_ff;
      req_stall     = 1'b1;
      div_start     = 1'b0;
      div_num       = rad_ff;
      div_den       = guess_ff;
      unique case (state_ff)
         nsr_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            div_num   = req_radicand;
            div_den   = ONE_FIXED;
            if (req_valid) begin
               div_start = 1'b1;
               rad_in    = req_radicand;
               guess_in  = ONE_FIXED;
               rounds_in = '0;
               state_in  = nsr_pkg::ST_DIVIDE;
            end
         end
         nsr_pkg::ST_DIVIDE: begin
            if (div_done) begin
               state_in = nsr_pkg::ST_UPDATE;
            end
         end
         nsr_pkg::ST_UPDATE: begin
            guess_in     = sum[VALUE_WIDTH:1];
            quot_hold_in = div_quot;
            rounds_in    = rounds_ff + 1'b1;
            state_in     = nsr_pkg::ST_CHECK;
         end
         nsr_pkg::ST_CHECK: begin
            err_over_in = err > VALUE_WIDTH'(tolerance_ff);
            if (err_over_in && rounds_ff < cap_eff) begin
               div_start = 1'b1;
               state_in  = nsr_pkg::ST_DIVIDE;
            end else begin
               state_in = nsr_pkg::ST_FINISH;
            end
         end
         nsr_pkg::ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_root_in   = guess_ff;
               rsp_rounds_in = rounds_ff;
               rsp_cap_in    = err_over_ff;
               state_in      = nsr_pkg::ST_IDLE;
            end
         end
         default: state_in = nsr_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      rad_ff        <= rad_in;
      guess_ff      <= guess_in;
      quot_hold_ff  <= quot_hold_in;
      rounds_ff     <= rounds_in;
      err_over_ff   <= err_over_in;
      rsp_root_ff   <= rsp_root_in;
      rsp_rounds_ff <= rsp_rounds_in;
      rsp_cap_ff    <= rsp_cap_in;
      if (reset) begin
         state_ff     <= nsr_pkg::ST_IDLE;
         tolerance_ff <= nsr_pkg::TOLERANCE_RESET;
         cap_ff       <= nsr_pkg::ITERATION_CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tolerance_ff <= tolerance_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_root        = rsp_root_ff;
   assign rsp_rounds_used = rsp_rounds_ff;
   assign rsp_cap_reached = rsp_cap_ff;

endmodule
`default_nettype wire

[hw/rtl/nsr_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nsr_checker
// Port-level checks for the Newton square root block.
// ----------------------------------------------------------------------------
module nsr_checker #(
   parameter int VALUE_WIDTH = 32
) (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_stall,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire logic [VALUE_WIDTH-1:0]        rsp_root,
   input wire logic [nsr_pkg::CAP_WIDTH-1:0] rsp_rounds_used,
   input wire logic                          rsp_cap_reached
);

   // no result survives a reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a taken request keeps the block busy for at least a divide
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous one still in flight");

   // every result reports at least one round
   a_rounds_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_rounds_used != '0)
      else $error("result reports zero rounds");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_root)
         && $stable(rsp_rounds_used) && $stable(rsp_cap_reached))
      else $error("stalled result changed");

endmodule

bind newton_square_root nsr_checker #(
   .VALUE_WIDTH (VALUE_WIDTH)
) u_nsr_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_root        (rsp_root),
   .rsp_rounds_used (rsp_rounds_used),
   .rsp_cap_reached (rsp_cap_reached)
);
`default_nettype wire

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for newton_square_root. A directed table covers the
// reset settings, field extremes, a cap of zero, caps past 64 and both
// tolerance extremes. Random phases follow, each under its own tolerance and
// cap. Each response is checked against a typed-in result or a Heron iteration model.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int          FRAC_BITS    = 16;
   localparam int          VALUE_W      = 32;
   localparam int          HOLD_CYCLES  = 5000;
   localparam int          TAIL_CYCLES  = 200;
   localparam int unsigned CYCLE_LIMIT  = 10_000_000;
   localparam int          PHASE_COUNT  = 8;
   localparam int          PHASE_ITEMS  = 80;
   localparam int          PROBE_COUNT  = 22;

   typedef struct packed {
      logic [VALUE_W-1:0]            root;
      logic [nsr_pkg::CAP_WIDTH-1:0] rounds;
      logic                          capped;
   } sqrt_result_type;

   typedef struct packed {
      logic [nsr_pkg::TOL_WIDTH-1:0] tol;
      logic [nsr_pkg::CAP_WIDTH-1:0] cap;
      logic [VALUE_W-1:0]            radicand;
      logic                          known;
      sqrt_result_type               result;
   } probe_row_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           csr_write_enable = 1'b0;
   nsr_pkg::csr_index_type         csr_index = nsr_pkg::CSR_TOLERANCE;
   logic [nsr_pkg::CSR_WIDTH-1:0]  csr_write_data = '0;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic [VALUE_W-1:0]             req_radicand = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic [VALUE_W-1:0]             rsp_root;
   logic [nsr_pkg::CAP_WIDTH-1:0]  rsp_rounds_used;
   logic                           rsp_cap_reached;

   // model copy of the two registers
   logic [nsr_pkg::TOL_WIDTH-1:0]  tol_setting = nsr_pkg::TOLERANCE_RESET;
   logic [nsr_pkg::CAP_WIDTH-1:0]  cap_setting = nsr_pkg::ITERATION_CAP_RESET;

   sqrt_result_type       expected_roots[$];
   int                    mismatches = 0;
   int                    results_seen = 0;
   int                    capped_seen = 0;
   int                    most_rounds = 0;
   int                    requests_sent = 0;
   int                    settings_used = 1;
   bit                    hold_pending = 1'b0;
   bit                    sender_steady = 1'b0;
   bit                    receiver_steady = 1'b0;

   // directed requests; result typed in only where it is obvious
   probe_row_type probes [PROBE_COUNT] = '{
      '{16'd7,     7'd32,  32'h0001_0000, 1'b1, '{32'h0001_0000, 7'd1,  1'b0}},
      '{16'd7,     7'd32,  32'h0000_0000, 1'b1, '{32'h0000_0004, 7'd14, 1'b0}},
      '{16'd7,     7'd32,  32'hFFFF_FFFF, 1'b0, '0},
      '{16'd7,     7'd32,  32'h0000_0001, 1'b0, '0},
      '{16'd7,     7'd32,  32'h0004_0000, 1'b0, '0},
      '{16'd7,     7'd32,  32'h0002_0000, 1'b0, '0},
      '{16'd7,     7'd32,  32'h8000_0000, 1'b0, '0},
      '{16'd7,     7'd32,  32'h0000_FFFF, 1'b0, '0},
      '{16'd7,     7'd32,  32'h5555_5555, 1'b0, '0},
      '{16'd7,     7'd32,  32'hAAAA_AAAA, 1'b0, '0},
      '{16'hFFFF,  7'd32,  32'hFFFF_FFFF, 1'b0, '0},
      '{16'hFFFF,  7'd32,  32'h0001_0000, 1'b1, '{32'h0001_0000, 7'd1,  1'b0}},
      '{16'hFFFF,  7'd1,   32'h0009_0000, 1'b1, '{32'h0005_0000, 7'd1,  1'b1}},
      // cap of zero behaves as a cap of one
      '{16'd7,     7'd0,   32'h0009_0000, 1'b1, '{32'h0005_0000, 7'd1,  1'b1}},
      '{16'd7,     7'd0,   32'h0001_0000, 1'b1, '{32'h0001_0000, 7'd1,  1'b0}},
      '{16'd0,     7'd127, 32'hFFFF_FFFF, 1'b0, '0},
      '{16'd0,     7'd127, 32'h0000_0002, 1'b0, '0},
      // zero radicand: guess halves down to zero
      '{16'd0,     7'd127, 32'h0000_0000, 1'b1, '{32'h0000_0000, 7'd17, 1'b0}},
      '{16'd0,     7'd64,  32'h1234_5678, 1'b0, '0},
      '{16'd0,     7'd64,  32'hFFFF_0000, 1'b0, '0},
      '{16'd1,     7'd64,  32'h0000_0100, 1'b0, '0},
      '{16'hFFFF,  7'd127, 32'h0000_0000, 1'b1, '{32'h0000_8000, 7'd1,  1'b0}}
   };

   newton_square_root #(
      .FRACTION_BITS (FRAC_BITS),
      .VALUE_WIDTH   (VALUE_W)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_radicand     (req_radicand),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_root         (rsp_root),
      .rsp_rounds_used  (rsp_rounds_used),
      .rsp_cap_reached  (rsp_cap_reached)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // (num << FRAC_BITS) / den, truncated; saturates when it overflows or den is 0
   function automatic logic [VALUE_W-1:0] fixed_quotient(input logic [VALUE_W-1:0] num,
                                                         input logic [VALUE_W-1:0] den);
      logic [VALUE_W+FRAC_BITS-1:0] wide;
      if (den == '0) return '1;
      wide = {num, {FRAC_BITS{1'b0}}} / {{FRAC_BITS{1'b0}}, den};
      if (wide[VALUE_W+FRAC_BITS-1:VALUE_W] != '0) return '1;
      return wide[VALUE_W-1:0];
   endfunction

   function automatic sqrt_result_type heron_root(
         input logic [VALUE_W-1:0]            radicand,
         input logic [nsr_pkg::TOL_WIDTH-1:0] tol,
         input logic [nsr_pkg::CAP_WIDTH-1:0] cap);
      logic [VALUE_W-1:0]            guess;
      logic [VALUE_W-1:0]            quot;
      logic [VALUE_W-1:0]            mean;
      logic [VALUE_W-1:0]            err;
      logic [VALUE_W:0]              sum;
      logic [nsr_pkg::CAP_WIDTH-1:0] limit;
      logic [nsr_pkg::CAP_WIDTH-1:0] rounds;
      sqrt_result_type               res;
      guess  = VALUE_W'(1) << FRAC_BITS;
      limit  = (cap == '0) ? nsr_pkg::CAP_WIDTH'(1) : cap;
      rounds = '0;
      do begin
         quot   = fixed_quotient(radicand, guess);
         sum    = {1'b0, quot} + {1'b0, guess};
         mean   = sum[VALUE_W:1];
         err    = (mean >= quot) ? mean - quot : quot - mean;
         guess  = mean;
         rounds = rounds + nsr_pkg::CAP_WIDTH'(1);
      end while (err > VALUE_W'(tol) && rounds < limit);
      res.root   = guess;
      res.rounds = rounds;
      res.capped = err > VALUE_W'(tol);
      return res;
   endfunction

   function automatic int pick_gap(input bit steady);
      int unsigned r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic [VALUE_W-1:0] pick_radicand();
      int unsigned        w;
      logic [15:0]        m;
      logic [VALUE_W-1:0] v;
      case ($urandom_range(0, 9))
         3, 4: begin
            w = $urandom_range(0, 32);
            v = (w == 32) ? $urandom : ($urandom & ((VALUE_W'(1) << w) - 1));
         end
         5: begin
            // exact squares, both integer and fractional
            m = $urandom_range(0, 255);
            v = $urandom_range(0, 1) ? {16'(m * m), 16'h0} : VALUE_W'(m) * VALUE_W'(m);
         end
         6: v = VALUE_W'(1) << $urandom_range(0, 31);
         7: begin
            case ($urandom_range(0, 3))
               0: v = '0;
               1: v = 32'h0000_0001;
               2: v = '1;
               default: v = 32'h0001_0000;
            endcase
         end
         8: v = (VALUE_W'(1) << $urandom_range(0, 31)) ^ VALUE_W'($urandom_range(0, 7));
         default: v = $urandom;
      endcase
      return v;
   endfunction

   task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                  input logic [VALUE_W-1:0] want);
      $display("MISMATCH %s: got 0x%08h want 0x%08h at %0t", what, got, want, $time);
      mismatches++;
   endtask

   task automatic check_root();
      sqrt_result_type want;
      if (expected_roots.size() == 0) begin
         report_mismatch("response with no request pending", rsp_root, '0);
         return;
      end
      want = expected_roots.pop_front();
      if (rsp_root !== want.root)
         report_mismatch("root", rsp_root, want.root);
      if (rsp_rounds_used !== want.rounds)
         report_mismatch("rounds_used", VALUE_W'(rsp_rounds_used), VALUE_W'(want.rounds));
      if (rsp_cap_reached !== want.capped)
         report_mismatch("cap_reached", VALUE_W'(rsp_cap_reached), VALUE_W'(want.capped));
      results_seen++;
      if (rsp_cap_reached) capped_seen++;
      if (int'(rsp_rounds_used) > most_rounds) most_rounds = int'(rsp_rounds_used);
   endtask

   // response side: check on the rising edge, choose stall on the falling edge
   initial begin
      int stall_left;
      int unsigned r;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) check_root();
         @(negedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            stall_left   = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            rsp_stall = 1'b1;
            stall_left--;
         end else if (receiver_steady) begin
            rsp_stall = 1'b0;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
               rsp_stall = 1'b0;
            end else if (r < 92) begin
               rsp_stall  = 1'b1;
               stall_left = $urandom_range(0, 3);
            end else begin
               rsp_stall  = 1'b1;
               stall_left = $urandom_range(10, 80);
            end
         end
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("timeout after %0d cycles, %0d responses outstanding",
               CYCLE_LIMIT, expected_roots.size());
      $display("tb_top failed");
      $finish;
   end

   task automatic write_csr(input nsr_pkg::csr_index_type        index,
                            input logic [nsr_pkg::CSR_WIDTH-1:0] data);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index        = index;
      csr_write_data   = data;
      if (index == nsr_pkg::CSR_TOLERANCE) tol_setting = data[nsr_pkg::TOL_WIDTH-1:0];
      else                                 cap_setting = data[nsr_pkg::CAP_WIDTH-1:0];
      @(negedge clock);
      csr_write_enable = 1'b0;
      // junk on the port while the enable is low
      csr_index        = nsr_pkg::csr_index_type'($urandom_range(0, 1));
      csr_write_data   = nsr_pkg::CSR_WIDTH'($urandom);
   endtask

   // withdraw the request and wait until every response is back
   task automatic wait_all_roots();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_roots.size() != 0) @(posedge clock);
   endtask

   task automatic apply_setting(input logic [nsr_pkg::TOL_WIDTH-1:0] tol,
                                input logic [nsr_pkg::CSR_WIDTH-1:0] cap_word);
      wait_all_roots();
      write_csr(nsr_pkg::CSR_TOLERANCE, nsr_pkg::CSR_WIDTH'(tol));
      write_csr(nsr_pkg::CSR_ITERATION_CAP, cap_word);
      settings_used++;
   endtask

   // offer one request and return on the edge that takes it
   task automatic send_radicand(input logic [VALUE_W-1:0] radicand, input int gap);
      @(negedge clock);
      if (gap > 0) begin
         req_valid    = 1'b0;
         req_radicand = $urandom;
         repeat (gap) @(negedge clock);
      end
      req_valid    = 1'b1;
      req_radicand = radicand;
      do @(posedge clock); while (req_stall);
      requests_sent++;
   endtask

   initial begin
      logic [nsr_pkg::TOL_WIDTH-1:0] tol;
      logic [nsr_pkg::CAP_WIDTH-1:0] cap;
      logic [VALUE_W-1:0]            radicand;
      int                            count;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table, starting at the reset settings
      for (int i = 0; i < PROBE_COUNT; i++) begin
         if (probes[i].tol != tol_setting || probes[i].cap != cap_setting)
            apply_setting(probes[i].tol, nsr_pkg::CSR_WIDTH'(probes[i].cap));
         send_radicand(probes[i].radicand, pick_gap(1'b0));
         if (probes[i].known) expected_roots.push_back(probes[i].result);
         else expected_roots.push_back(heron_root(probes[i].radicand,
                                                  tol_setting, cap_setting));
      end

      for (int p = 0; p < PHASE_COUNT; p++) begin
         count = PHASE_ITEMS;
         case (p)
            0: begin
               tol = nsr_pkg::TOLERANCE_RESET;
               cap = nsr_pkg::ITERATION_CAP_RESET;
            end
            1: begin tol = '0;              cap = 7'd64; end
            2: begin tol = '1;              cap = 7'd64; end
            3: begin
               tol = nsr_pkg::TOL_WIDTH'($urandom_range(0, 255));
               cap = nsr_pkg::CAP_WIDTH'($urandom_range(1, 64));
            end
            4: begin
               tol = nsr_pkg::TOL_WIDTH'($urandom);
               cap = nsr_pkg::CAP_WIDTH'($urandom_range(1, 64));
            end
            5: begin tol = '0;              cap = 7'd127; count = 12; end
            6: begin tol = 16'd3;           cap = 7'd1; end
            default: begin
               tol = nsr_pkg::TOL_WIDTH'($urandom_range(0, 31));
               cap = 7'd20;
            end
         endcase
         // upper data bits of the cap write are don't-care
         apply_setting(tol, {9'($urandom), cap});
         sender_steady   = (p % 3 == 1);
         receiver_steady = (p % 3 == 1);
         // long hold-off on the response side while requests keep coming
         if (p == 0 || p == 3) hold_pending = 1'b1;
         for (int i = 0; i < count; i++) begin
            if (i == count / 2 || $urandom_range(0, 39) == 0) wait_all_roots();
            radicand = pick_radicand();
            send_radicand(radicand, pick_gap(sender_steady));
            expected_roots.push_back(heron_root(radicand, tol_setting, cap_setting));
         end
      end

      @(negedge clock);
      req_valid = 1'b0;
      wait_all_roots();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("%0d requests checked under %0d register settings, %0d mismatches",
               results_seen, settings_used, mismatches);
      $display("%0d responses stopped by the cap, longest run %0d rounds",
               capped_seen, most_rounds);
      if (mismatches == 0 && expected_roots.size() == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
